// ----- rtl/core/xed_pkg.sv -----
// Package for the XML entity decoder: item and command types, codes,
// character constants and small lookup functions. No dependencies.
package xed_pkg;

  localparam int unsigned MaxEntityLen = 16;
  localparam int unsigned CntW         = $clog2(MaxEntityLen + 1);
  localparam int unsigned AddrW        = $clog2(MaxEntityLen);
  localparam int unsigned PairDepth    = MaxEntityLen / 2;
  localparam int unsigned PairAW       = $clog2(PairDepth);
  localparam int unsigned PairCntW     = $clog2(PairDepth + 1);
  localparam int unsigned CmdDepth     = 4;
  localparam int unsigned CmdAW        = $clog2(CmdDepth);
  localparam int unsigned ResDepth     = 4;
  localparam int unsigned ResAW        = $clog2(ResDepth);
  localparam int unsigned NumNames     = 5;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLess  = 8'h3C;
  localparam logic [7:0] ChMore  = 8'h3E;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_error;
    logic       out_last;
  } res_item_t;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ENTITY,
    MODE_DISCARD
  } mode_e;

  typedef enum logic [2:0] {
    CMD_TEXT,
    CMD_STORE,
    CMD_CLOSE_ONE,
    CMD_CLOSE_HEX,
    CMD_FLUSH,
    CMD_ABORT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic       pair_vld;
    logic [7:0] pair;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FLUSH_BUF,
    BK_FLUSH_TAIL,
    BK_HEX
  } back_state_e;

  typedef enum logic [2:0] {
    NM_LT,
    NM_GT,
    NM_AMP,
    NM_APOS,
    NM_QUOT
  } name_e;

  // Entity names, left aligned, one byte per character.
  function automatic logic [31:0] name_str(input name_e j);
    logic [31:0] s;
    case (j)
      NM_LT:   s = 32'h6C74_0000;
      NM_GT:   s = 32'h6774_0000;
      NM_AMP:  s = 32'h616D_7000;
      NM_APOS: s = 32'h6170_6F73;
      NM_QUOT: s = 32'h7175_6F74;
      default: s = 32'h0000_0000;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] name_char(input name_e j, input logic [1:0] k);
    logic [31:0] s;
    s = name_str(j);
    return s[8 * (3 - k) +: 8];
  endfunction

  function automatic logic [CntW-1:0] name_len(input name_e j);
    logic [CntW-1:0] n;
    case (j)
      NM_LT:   n = CntW'(2);
      NM_GT:   n = CntW'(2);
      NM_AMP:  n = CntW'(3);
      NM_APOS: n = CntW'(4);
      NM_QUOT: n = CntW'(4);
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_value(input name_e j);
    logic [7:0] v;
    case (j)
      NM_LT:   v = ChLess;
      NM_GT:   v = ChMore;
      NM_AMP:  v = ChAmp;
      NM_APOS: v = ChApos;
      NM_QUOT: v = ChQuote;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Returns {valid, nibble} for one hex digit of either case.
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else begin
      r = 5'b0_0000;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/xed_cmd_fifo.sv -----
// Command queue between the front and the back of the entity decoder.
// Depends on xed_pkg for the command type and depth.
module xed_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  xed_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          vld_o,
  output xed_pkg::cmd_t data_o
);

  xed_pkg::cmd_t                 mem_q [xed_pkg::CmdDepth];
  logic [xed_pkg::CmdAW-1:0]     wptr_q, wptr_d;
  logic [xed_pkg::CmdAW-1:0]     rptr_q, rptr_d;
  logic [xed_pkg::CmdAW:0]       cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o = (cnt_q == (xed_pkg::CmdAW + 1)'(xed_pkg::CmdDepth));
  assign vld_o  = (cnt_q != '0);
  assign data_o = mem_q[rptr_q];
  assign do_wr  = wr_i && !full_o;
  assign do_rd  = rd_i && vld_o;

  always_comb begin
    wptr_d = do_wr ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_rd ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/xed_res_fifo.sv -----
// Result queue at the output of the entity decoder.
// Depends on xed_pkg for the result type and depth.
module xed_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  xed_pkg::res_item_t data_i,
  output logic               full_o,
  input  logic               rd_i,
  output logic               empty_o,
  output xed_pkg::res_item_t data_o
);

  xed_pkg::res_item_t            mem_q [xed_pkg::ResDepth];
  logic [xed_pkg::ResAW-1:0]     wptr_q, wptr_d;
  logic [xed_pkg::ResAW-1:0]     rptr_q, rptr_d;
  logic [xed_pkg::ResAW:0]       cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o  = (cnt_q == (xed_pkg::ResAW + 1)'(xed_pkg::ResDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = do_wr ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_rd ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/xed_front.sv -----
// Front end of the entity decoder: tracks text/entity/discard mode, checks
// the entity name as it arrives and issues at most one command per byte. Uses xed_pkg.
module xed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  xed_pkg::in_item_t in_item_i,
  output logic              cmd_vld_o,
  output xed_pkg::cmd_t     cmd_o
);

  xed_pkg::mode_e                 mode_q, mode_d;
  logic [xed_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                           hash_q, hash_d;
  logic                           hex_q, hex_d;
  logic                           dig_ok_q, dig_ok_d;
  logic [7:0]                     acc_q, acc_d;
  logic [3:0]                     nib_q, nib_d;
  logic [xed_pkg::NumNames-1:0]   nm_q, nm_d;

  logic [7:0]                     b;
  logic                           last;
  logic [4:0]                     hv;
  logic                           is_dig;
  logic                           hex_ok, dec_ok, named_ok;
  logic [7:0]                     named_val;
  xed_pkg::name_e                 nm_idx;

  assign b      = in_item_i.in_byte;
  assign last   = in_item_i.in_last;
  assign hv     = xed_pkg::hex_nib(b);
  assign is_dig = (b >= xed_pkg::ChZero) && (b <= xed_pkg::ChNine);

  // Verdict on the buffered name, valid when the semicolon arrives.
  always_comb begin
    hex_ok    = hash_q && hex_q && (cnt_q > xed_pkg::CntW'(2)) && !cnt_q[0] && dig_ok_q;
    dec_ok    = hash_q && !hex_q && (cnt_q >= xed_pkg::CntW'(2)) && dig_ok_q;
    named_ok  = 1'b0;
    named_val = 8'h00;
    for (int j = 0; j < xed_pkg::NumNames; j++) begin
      nm_idx = xed_pkg::name_e'(j[2:0]);
      if (!hash_q && (cnt_q != '0) && nm_q[j] && (cnt_q == xed_pkg::name_len(nm_idx))) begin
        named_ok  = 1'b1;
        named_val = xed_pkg::name_value(nm_idx);
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    hash_d   = hash_q;
    hex_d    = hex_q;
    dig_ok_d = dig_ok_q;
    acc_d    = acc_q;
    nib_d    = nib_q;
    nm_d     = nm_q;
    cmd_vld_o = 1'b0;
    cmd_o     = '{kind: xed_pkg::CMD_TEXT, data: b, last: last, pair_vld: 1'b0, pair: 8'h00};

    case (mode_q)
      xed_pkg::MODE_ENTITY: begin
        if (b == xed_pkg::ChSemi) begin
          cmd_vld_o = 1'b1;
          cnt_d     = '0;
          mode_d    = xed_pkg::MODE_TEXT;
          if (hex_ok) begin
            cmd_o.kind = xed_pkg::CMD_CLOSE_HEX;
          end else if (dec_ok) begin
            cmd_o.kind = xed_pkg::CMD_CLOSE_ONE;
            cmd_o.data = acc_q;
          end else if (named_ok) begin
            cmd_o.kind = xed_pkg::CMD_CLOSE_ONE;
            cmd_o.data = named_val;
          end else begin
            cmd_o.kind = xed_pkg::CMD_ABORT;
            cmd_o.data = 8'h00;
            mode_d     = last ? xed_pkg::MODE_TEXT : xed_pkg::MODE_DISCARD;
          end
        end else if (last) begin
          // Unterminated entity: replay it literally.
          cmd_vld_o  = 1'b1;
          cmd_o.kind = xed_pkg::CMD_FLUSH;
          cnt_d      = '0;
          mode_d     = xed_pkg::MODE_TEXT;
        end else if (cnt_q >= xed_pkg::CntW'(xed_pkg::MaxEntityLen)) begin
          cmd_vld_o  = 1'b1;
          cmd_o.kind = xed_pkg::CMD_ABORT;
          cmd_o.data = 8'h00;
          cmd_o.last = 1'b1;
          cnt_d      = '0;
          mode_d     = xed_pkg::MODE_DISCARD;
        end else begin
          cmd_vld_o  = 1'b1;
          cmd_o.kind = xed_pkg::CMD_STORE;
          cnt_d      = cnt_q + 1'b1;
          if (cnt_q == '0) begin
            hash_d   = (b == xed_pkg::ChHash);
            dig_ok_d = 1'b1;
            acc_d    = 8'h00;
            for (int j = 0; j < xed_pkg::NumNames; j++) begin
              nm_d[j] = (b == xed_pkg::name_char(xed_pkg::name_e'(j[2:0]), 2'd0));
            end
          end else begin
            for (int j = 0; j < xed_pkg::NumNames; j++) begin
              nm_d[j] = nm_q[j]
                     && (cnt_q < xed_pkg::name_len(xed_pkg::name_e'(j[2:0])))
                     && (b == xed_pkg::name_char(xed_pkg::name_e'(j[2:0]), cnt_q[1:0]));
            end
            if (cnt_q == xed_pkg::CntW'(1)) begin
              hex_d = (b == xed_pkg::ChLowX);
            end
            if (hash_q && !((cnt_q == xed_pkg::CntW'(1)) && (b == xed_pkg::ChLowX))) begin
              if (hex_q && (cnt_q >= xed_pkg::CntW'(2))) begin
                dig_ok_d = dig_ok_q && hv[4];
                if (!cnt_q[0]) begin
                  nib_d = hv[3:0];
                end else begin
                  cmd_o.pair_vld = 1'b1;
                  cmd_o.pair     = {nib_q, hv[3:0]};
                end
              end else begin
                dig_ok_d = dig_ok_q && is_dig;
                acc_d    = (acc_q << 3) + (acc_q << 1) + (b - xed_pkg::ChZero);
              end
            end
          end
        end
      end
      xed_pkg::MODE_DISCARD: begin
        if (last) begin
          mode_d = xed_pkg::MODE_TEXT;
        end
      end
      default: begin
        mode_d = xed_pkg::MODE_TEXT;
        if ((b == xed_pkg::ChAmp) && !last) begin
          mode_d = xed_pkg::MODE_ENTITY;
          cnt_d  = '0;
        end else begin
          cmd_vld_o = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= xed_pkg::MODE_TEXT;
      cnt_q    <= '0;
      hash_q   <= 1'b0;
      hex_q    <= 1'b0;
      dig_ok_q <= 1'b0;
      acc_q    <= 8'h00;
      nib_q    <= 4'h0;
      nm_q     <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      hash_q   <= hash_d;
      hex_q    <= hex_d;
      dig_ok_q <= dig_ok_d;
      acc_q    <= acc_d;
      nib_q    <= nib_d;
      nm_q     <= nm_d;
    end
  end

endmodule

// ----- rtl/core/xed_back.sv -----
// Back end of the entity decoder: stores entity bytes and decoded hex pairs
// and emits results into the result queue, one per cycle while it has room. Uses xed_pkg.
module xed_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_vld_i,
  input  xed_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output xed_pkg::res_item_t res_o
);

  logic [7:0]                    buf_q  [xed_pkg::MaxEntityLen];
  logic [7:0]                    pair_q [xed_pkg::PairDepth];

  xed_pkg::back_state_e          state_q, state_d;
  logic [xed_pkg::CntW-1:0]      wr_q, wr_d;
  logic [xed_pkg::PairCntW-1:0]  pr_q, pr_d;
  logic [xed_pkg::CntW-1:0]      idx_q, idx_d;
  logic [7:0]                    tail_q, tail_d;
  logic                          last_q, last_d;
  logic                          buf_we, pair_we;
  logic [7:0]                    buf_rd, pair_rd;
  logic                          hex_end;

  assign buf_rd  = buf_q[idx_q[xed_pkg::AddrW-1:0]];
  assign pair_rd = pair_q[idx_q[xed_pkg::PairAW-1:0]];
  assign hex_end = (idx_q == (xed_pkg::CntW'(pr_q) - xed_pkg::CntW'(1)));

  always_comb begin
    state_d    = state_q;
    wr_d       = wr_q;
    pr_d       = pr_q;
    idx_d      = idx_q;
    tail_d     = tail_q;
    last_d     = last_q;
    buf_we     = 1'b0;
    pair_we    = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{out_byte: cmd_i.data, out_error: 1'b0, out_last: cmd_i.last};

    case (state_q)
      xed_pkg::BK_IDLE: begin
        if (cmd_vld_i) begin
          case (cmd_i.kind)
            xed_pkg::CMD_STORE: begin
              buf_we    = 1'b1;
              wr_d      = wr_q + 1'b1;
              cmd_pop_o = 1'b1;
              if (cmd_i.pair_vld) begin
                pair_we = 1'b1;
                pr_d    = pr_q + 1'b1;
              end
            end
            xed_pkg::CMD_TEXT: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end
            xed_pkg::CMD_CLOSE_ONE: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                wr_d       = '0;
                pr_d       = '0;
              end
            end
            xed_pkg::CMD_ABORT: begin
              res_o = '{out_byte: 8'h00, out_error: 1'b1, out_last: 1'b1};
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                wr_d       = '0;
                pr_d       = '0;
              end
            end
            xed_pkg::CMD_CLOSE_HEX: begin
              res_o.out_byte = pair_rd;
              res_o.out_last = cmd_i.last && (pr_q == xed_pkg::PairCntW'(1));
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                if (pr_q == xed_pkg::PairCntW'(1)) begin
                  wr_d = '0;
                  pr_d = '0;
                end else begin
                  idx_d   = xed_pkg::CntW'(1);
                  last_d  = cmd_i.last;
                  state_d = xed_pkg::BK_HEX;
                end
              end
            end
            xed_pkg::CMD_FLUSH: begin
              res_o.out_byte = xed_pkg::ChAmp;
              res_o.out_last = 1'b0;
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                tail_d     = cmd_i.data;
                last_d     = cmd_i.last;
                state_d    = (wr_q == '0) ? xed_pkg::BK_FLUSH_TAIL : xed_pkg::BK_FLUSH_BUF;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      xed_pkg::BK_FLUSH_BUF: begin
        res_o = '{out_byte: buf_rd, out_error: 1'b0, out_last: 1'b0};
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (idx_q == (wr_q - 1'b1)) begin
            idx_d   = '0;
            state_d = xed_pkg::BK_FLUSH_TAIL;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      xed_pkg::BK_FLUSH_TAIL: begin
        res_o = '{out_byte: tail_q, out_error: 1'b0, out_last: last_q};
        if (!res_full_i) begin
          res_push_o = 1'b1;
          wr_d       = '0;
          pr_d       = '0;
          idx_d      = '0;
          state_d    = xed_pkg::BK_IDLE;
        end
      end
      xed_pkg::BK_HEX: begin
        res_o = '{out_byte: pair_rd, out_error: 1'b0, out_last: last_q && hex_end};
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (hex_end) begin
            wr_d    = '0;
            pr_d    = '0;
            idx_d   = '0;
            state_d = xed_pkg::BK_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = xed_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xed_pkg::BK_IDLE;
      wr_q    <= '0;
      pr_q    <= '0;
      idx_q   <= '0;
      tail_q  <= 8'h00;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      pr_q    <= pr_d;
      idx_q   <= idx_d;
      tail_q  <= tail_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[wr_q[xed_pkg::AddrW-1:0]] <= cmd_i.data;
    end
    if (pair_we) begin
      pair_q[pr_q[xed_pkg::PairAW-1:0]] <= cmd_i.pair;
    end
  end

endmodule

// ----- rtl/core/xml_entity_decoder.sv -----
// Path: a text byte passes the registered command and result queues before it shows on the result ports.
// Throughput: one input transaction per cycle while the command queue has room;
//   the back end emits one result per cycle while the result queue has room; a closed
//   hex entity gives one result per byte pair, an unterminated one is replayed literally.
// Reset: rst_ni clears mode, counters and queues at once; the entity stores are
//   not cleared and are only read after being written.
// Top level of the XML entity decoder; uses xed_pkg, xed_front, xed_cmd_fifo,
// xed_back and xed_res_fifo.
module xml_entity_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  xed_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output xed_pkg::res_item_t out_item_o
);

  // The front end sees every accepted input transaction. It keeps the text,
  // entity and discard modes and judges the entity name while its bytes
  // arrive, so that when the semicolon comes the verdict is already known.
  logic               accept;
  logic               cmd_vld;
  xed_pkg::cmd_t      cmd_in;

  // The command queue decouples the two halves: the front keeps taking bytes
  // while the back is busy replaying a long entity into a full result queue.
  logic               cmd_full;
  logic               cmd_avail;
  logic               cmd_pop;
  xed_pkg::cmd_t      cmd_out;

  // The back end owns the entity byte store and the decoded hex pairs, and
  // sequences multi-result bursts one result per cycle while the result queue has room.
  logic               res_full;
  logic               res_push;
  xed_pkg::res_item_t res_in;

  // Every accepted byte reaches the front; only some produce a command.
  // The queue is checked as full before any classification, which keeps
  // the full flag free of any path from the input byte.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  xed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .cmd_vld_o (cmd_vld),
    .cmd_o     (cmd_in)
  );

  xed_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept && cmd_vld),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .rd_i   (cmd_pop),
    .vld_o  (cmd_avail),
    .data_o (cmd_out)
  );

  xed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (cmd_avail),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // The result queue absorbs the short bursts that entity closures produce
  // and presents the oldest result while empty is low.
  xed_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .empty_o (empty),
    .data_o  (out_item_o)
  );

endmodule

// ----- rtl/core/xed_checker.sv -----
// Port-level checks for the XML entity decoder, bound to the top level.
// Depends on xed_pkg and on the xml_entity_decoder ports.
module xed_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input xed_pkg::in_item_t  in_item_i,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input xed_pkg::res_item_t out_item_o
);

  // An error transaction always ends its string and carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.out_error) |-> (out_item_o.out_last && (out_item_o.out_byte == 8'h00)))
    else $error("error result without last flag or with nonzero byte");

  // A waiting result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

  // Leaving reset, the block holds no results and takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // An accepted input transaction carries known field values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> !$isunknown(in_item_i))
    else $error("input transaction with unknown bits");

  // The queue flags are always known once the block is out of reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({full, empty}))
    else $error("full or empty flag unknown");

endmodule

bind xml_entity_decoder xed_port_checks u_port_checks (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .in_item_i  (in_item_i),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
